/* rtl/aeb_pkg.sv */
// Shared constants, codes and types for the audio envelope binner.
package aeb_pkg;

  localparam int NUM_BINS     = 512;
  localparam int MAX_CHANNELS = 8;
  localparam int STRIDE       = 4;

  localparam int BIN_AW  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int FILL_W  = $clog2(NUM_BINS + 1);
  localparam int PHASE_W = (STRIDE > 1) ? $clog2(STRIDE) : 1;

  localparam int SAMPLE_W = 32;
  localparam int MAG_W    = 16;
  localparam int SUM_W    = MAG_W + ((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1);
  localparam int LEVEL_W  = 16;
  localparam int SPB_W    = 24;
  localparam int CH_W     = 4;
  localparam int DIV_W    = 40;
  localparam int DVSR_W   = 24;
  localparam int STEP_W   = $clog2(DIV_W + 1);

  localparam logic [LEVEL_W-1:0] FULL_SCALE = 16'd32768;

  // Sample formats
  localparam logic [1:0] FMT_S16 = 2'd0;
  localparam logic [1:0] FMT_S32 = 2'd1;
  localparam logic [1:0] FMT_U8  = 2'd2;

  // Request types
  localparam logic [1:0] REQ_FRAME  = 2'd0;
  localparam logic [1:0] REQ_FINISH = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_BIN     = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_SPB     = 2'd0;
  localparam logic [1:0] REG_CHANNEL = 2'd1;
  localparam logic [1:0] REG_FORMAT  = 2'd2;

  typedef logic [MAG_W-1:0]    mag_t;
  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic                start;
    logic [DIV_W-1:0]    dividend;
    logic [DVSR_W-1:0]   divisor;
    logic [STEP_W-1:0]   steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* rtl/aeb_lane.sv */
// One channel lane: turns a raw sample into a Q1.15 magnitude.
module aeb_lane
  import aeb_pkg::*;
(
  input  sample_t    sample,
  input  logic [1:0] sample_format,
  output mag_t       mag
);

  logic [15:0] s16;
  logic [31:0] abs32;
  logic [7:0]  u8;
  logic [7:0]  d8;

  always_comb begin
    s16   = sample[15:0];
    abs32 = sample[31] ? 32'(~sample + 32'd1) : sample;
    u8    = sample[7:0];
    d8    = (u8 >= 8'd128) ? 8'(u8 - 8'd128) : 8'(8'd128 - u8);
    case (sample_format)
      FMT_S16: mag = s16[15] ? 16'(17'h10000 - {1'b0, s16}) : s16;
      FMT_S32: mag = abs32[31:16];
      FMT_U8:  mag = {d8, 8'b0};
      default: mag = '0;
    endcase
  end

endmodule

/* rtl/aeb_merge.sv */
// Merge stage: registered sum of the lane magnitudes for the channels in use.
module aeb_merge
  import aeb_pkg::*;
(
  input  logic                     clk,
  input  mag_t                     mags [MAX_CHANNELS],
  input  logic [MAX_CHANNELS-1:0]  lane_en,
  output logic [SUM_W-1:0]         sum
);

  logic [SUM_W-1:0] sum_next;

  always_comb begin
    sum_next = '0;
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      if (lane_en[c]) sum_next = sum_next + SUM_W'(mags[c]);
    end
  end

  always_ff @(posedge clk) begin
    sum <= sum_next;
  end

endmodule

/* rtl/aeb_div.sv */
// Shared restoring divider, one quotient bit per cycle, caller-aligned dividend.
module aeb_div
  import aeb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [STEP_W-1:0] cnt;
  logic [DIV_W-1:0]  quo;
  logic [DVSR_W-1:0] rem;
  logic [DVSR_W-1:0] dvsr;
  logic              done;
  logic [DVSR_W+1:0] diff;
  logic              borrow;

  always_comb begin
    diff   = {1'b0, rem, quo[DIV_W-1]} - {2'b0, dvsr};
    borrow = diff[DVSR_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == STEP_W'(1));
      if (req.start) begin
        cnt <= req.steps;
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo  <= req.dividend;
      rem  <= '0;
      dvsr <= req.divisor;
    end else if (cnt != '0) begin
      // shift in the next dividend bit, keep the difference when it fits
      rem <= borrow ? {rem[DVSR_W-2:0], quo[DIV_W-1]} : diff[DVSR_W-1:0];
      quo <= {quo[DIV_W-2:0], ~borrow};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

/* rtl/audio_envelope_binner_core.sv */
// Top level of the audio envelope binner: control sequencer, lanes, bin store.
//
// Frames of up to eight channel samples come in on the input channel; every
// fourth frame is kept, its used channels are turned into Q1.15 magnitudes by
// eight parallel lanes, summed by the merge stage and averaged by a shared
// divider, and the mean is accumulated into the current bin. A closed bin is
// written to a 512-entry bin store and reported with the running peak. A
// finish request flushes any partial bin and finalizes the track; reads then
// return levels scaled to the peak. The single shared divider retires one
// quotient bit per cycle; it runs the 19-step channel mean of a kept frame, the
// 40-step bin mean of a frame that closes a bin or of a finish that flushes,
// and the 31-step normalization of a read once finalized with a nonzero peak.
// The emit cycle stretches while the output register still holds an untaken
// result. The input is stalled while an item is in work. One result register
// sits on the output, so the next item is accepted while a result still waits
// to be taken. The bin store has no reset; entries are only read below the fill
// count.
module audio_envelope_binner_core
  import aeb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,

  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [SPB_W-1:0]     cfg_data,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           req_type,
  input  logic signed [31:0]   sample_0,
  input  logic signed [31:0]   sample_1,
  input  logic signed [31:0]   sample_2,
  input  logic signed [31:0]   sample_3,
  input  logic signed [31:0]   sample_4,
  input  logic signed [31:0]   sample_5,
  input  logic signed [31:0]   sample_6,
  input  logic signed [31:0]   sample_7,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           result_kind,
  output logic [8:0]           bin_index,
  output logic [15:0]          level,
  output logic [15:0]          peak_level,
  output logic [9:0]           bins_filled,
  output logic                 finalized,
  output logic                 index_valid
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SUM    = 4'd1;
  localparam logic [3:0] S_MSTART = 4'd2;
  localparam logic [3:0] S_MEAN   = 4'd3;
  localparam logic [3:0] S_BSTART = 4'd4;
  localparam logic [3:0] S_BIN    = 4'd5;
  localparam logic [3:0] S_FDIV   = 4'd6;
  localparam logic [3:0] S_RDWAIT = 4'd7;
  localparam logic [3:0] S_NORM   = 4'd8;
  localparam logic [3:0] S_EMIT   = 4'd9;

  logic [3:0] state;

  // configuration
  logic [SPB_W-1:0] samples_per_bin;
  logic [CH_W-1:0]  channel_count;
  logic [1:0]       sample_format;

  // track state
  logic [DIV_W-1:0]   acc;
  logic [SPB_W-1:0]   frame_count;
  logic [PHASE_W-1:0] phase;
  logic [FILL_W-1:0]  filled;
  logic [LEVEL_W-1:0] peak;
  logic               done_flag;

  // captured item and staged result
  sample_t             samp_q [MAX_CHANNELS];
  logic [LEVEL_W-1:0]  rd_data;
  logic                rd_ok;
  logic [1:0]          res_kind;
  logic [8:0]          res_idx;
  logic [LEVEL_W-1:0]  res_level;
  logic                res_valid;

  logic [LEVEL_W-1:0]  bin_store [NUM_BINS];

  logic                accept;
  logic                emit_load;
  logic [CH_W-1:0]     ch_eff;
  logic [SPB_W-1:0]    spb_eff;
  logic [MAX_CHANNELS-1:0] lane_en;
  logic [SPB_W-1:0]    count_inc;
  logic                room;
  logic                flush_div;
  logic                norm_div;
  logic [LEVEL_W-1:0]  div_level;
  logic [PHASE_W-1:0]  phase_next;
  logic [SUM_W-1:0]    sum;
  mag_t                mags [MAX_CHANNELS];
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign emit_load = (state == S_EMIT) && (!out_valid || !out_stall);

  always_comb begin
    if (channel_count == '0) begin
      ch_eff = CH_W'(1);
    end else if (channel_count > CH_W'(MAX_CHANNELS)) begin
      ch_eff = CH_W'(MAX_CHANNELS);
    end else begin
      ch_eff = channel_count;
    end
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      lane_en[c] = (CH_W'(c) < ch_eff);
    end
    spb_eff    = (samples_per_bin == '0) ? SPB_W'(1) : samples_per_bin;
    count_inc  = frame_count + 1'b1;
    room       = (filled < FILL_W'(NUM_BINS));
    phase_next = (phase == PHASE_W'(STRIDE - 1)) ? '0 : PHASE_W'(phase + 1'b1);
    flush_div  = !done_flag && (frame_count != '0) && room;
    norm_div   = rd_ok && done_flag && (peak != '0);
    div_level  = div_rsp.quotient[LEVEL_W-1:0];
  end

  // lanes and merge
  for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_lane
    aeb_lane u_lane (
      .sample        (samp_q[g]),
      .sample_format (sample_format),
      .mag           (mags[g])
    );
  end

  aeb_merge u_merge (
    .clk     (clk),
    .mags    (mags),
    .lane_en (lane_en),
    .sum     (sum)
  );

  // divider requests: channel mean, bin mean, normalization
  always_comb begin
    div_req = '0;
    case (state)
      S_MSTART: begin
        div_req.start    = 1'b1;
        div_req.dividend = {sum, {(DIV_W - SUM_W){1'b0}}};
        div_req.divisor  = DVSR_W'(ch_eff);
        div_req.steps    = STEP_W'(SUM_W);
      end
      S_BSTART: begin
        div_req.start    = 1'b1;
        div_req.dividend = acc;
        div_req.divisor  = frame_count;
        div_req.steps    = STEP_W'(DIV_W);
      end
      S_IDLE: begin
        div_req.start    = accept && (req_type == REQ_FINISH) && flush_div;
        div_req.dividend = acc;
        div_req.divisor  = frame_count;
        div_req.steps    = STEP_W'(DIV_W);
      end
      S_RDWAIT: begin
        // level * 32768, aligned so that 31 steps cover it
        div_req.start    = norm_div;
        div_req.dividend = {rd_data, {(DIV_W - LEVEL_W){1'b0}}};
        div_req.divisor  = DVSR_W'(peak);
        div_req.steps    = STEP_W'(LEVEL_W + 15);
      end
      default: div_req = '0;
    endcase
  end

  aeb_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      samples_per_bin <= SPB_W'(1);
      channel_count   <= CH_W'(2);
      sample_format   <= FMT_S16;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SPB:     samples_per_bin <= cfg_data;
        REG_CHANNEL: channel_count   <= cfg_data[CH_W-1:0];
        REG_FORMAT:  sample_format   <= cfg_data[1:0];
        default:     ;
      endcase
    end
  end

  // sequencer and track state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      acc         <= '0;
      frame_count <= '0;
      phase       <= '0;
      filled      <= '0;
      peak        <= '0;
      done_flag   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (req_type)
              REQ_FRAME: begin
                // drop frames after finalization and hold the phase
                if (!done_flag && room) begin
                  phase <= phase_next;
                  if (phase == '0) state <= S_SUM;
                end
              end
              REQ_FINISH: begin
                if (done_flag) begin
                  state <= S_EMIT;
                end else if (flush_div) begin
                  state <= S_FDIV;
                end else begin
                  acc         <= '0;
                  frame_count <= '0;
                  done_flag   <= 1'b1;
                  state       <= S_EMIT;
                end
              end
              REQ_READ: state <= S_RDWAIT;
              REQ_CLEAR: begin
                acc         <= '0;
                frame_count <= '0;
                phase       <= '0;
                filled      <= '0;
                peak        <= '0;
                done_flag   <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_SUM:    state <= S_MSTART;
        S_MSTART: state <= S_MEAN;
        S_MEAN: begin
          if (div_rsp.done) begin
            acc         <= acc + DIV_W'(div_level);
            frame_count <= count_inc;
            state       <= (count_inc >= spb_eff) ? S_BSTART : S_IDLE;
          end
        end
        S_BSTART: state <= S_BIN;
        S_BIN, S_FDIV: begin
          if (div_rsp.done) begin
            filled      <= filled + 1'b1;
            if (div_level > peak) peak <= div_level;
            acc         <= '0;
            frame_count <= '0;
            // last bin or finish finalizes in the same step
            if (state == S_FDIV || filled + 1'b1 >= FILL_W'(NUM_BINS)) done_flag <= 1'b1;
            state       <= S_EMIT;
          end
        end
        S_RDWAIT: state <= norm_div ? S_NORM : S_EMIT;
        S_NORM:   if (div_rsp.done) state <= S_EMIT;
        S_EMIT:   if (emit_load) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  // captured samples, staged result fields
  always_ff @(posedge clk) begin
    if (accept) begin
      samp_q[0] <= sample_0;
      samp_q[1] <= sample_1;
      samp_q[2] <= sample_2;
      samp_q[3] <= sample_3;
      samp_q[4] <= sample_4;
      samp_q[5] <= sample_5;
      samp_q[6] <= sample_6;
      samp_q[7] <= sample_7;
      rd_ok     <= (sample_0 < 32'(filled));
      case (req_type)
        REQ_READ: begin
          res_kind  <= KIND_READ;
          res_idx   <= sample_0[8:0];
          res_level <= '0;
          res_valid <= 1'b0;
        end
        default: begin
          res_kind  <= KIND_SUMMARY;
          res_idx   <= '0;
          res_level <= '0;
          res_valid <= 1'b0;
        end
      endcase
    end else begin
      case (state)
        S_BIN: begin
          if (div_rsp.done) begin
            res_kind  <= KIND_BIN;
            res_idx   <= 9'(filled);
            res_level <= div_level;
          end
        end
        S_RDWAIT: begin
          res_valid <= rd_ok;
          res_level <= rd_ok ? rd_data : '0;
        end
        S_NORM: begin
          if (div_rsp.done) begin
            res_level <= (div_rsp.quotient > DIV_W'(FULL_SCALE)) ? FULL_SCALE : div_level;
          end
        end
        default: ;
      endcase
    end
  end

  // bin store: write on a closed or flushed bin, registered read
  always_ff @(posedge clk) begin
    if ((state == S_BIN || state == S_FDIV) && div_rsp.done) begin
      bin_store[filled[BIN_AW-1:0]] <= div_level;
    end
    if (accept) begin
      rd_data <= bin_store[sample_0[BIN_AW-1:0]];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      result_kind <= res_kind;
      bin_index   <= res_idx;
      level       <= res_level;
      peak_level  <= peak;
      bins_filled <= 10'(filled);
      finalized   <= done_flag;
      index_valid <= res_valid;
    end
  end

endmodule

/* dv/audio_envelope_binner_core_tb.sv */
// Self-checking testbench for audio_envelope_binner_core: random and directed requests.

typedef logic [31:0] frame_samples_t [aeb_pkg::MAX_CHANNELS];

typedef struct packed {
  logic [1:0]  kind;
  logic [8:0]  index;
  logic [15:0] level;
  logic [15:0] peak;
  logic [9:0]  filled;
  logic        fin;
  logic        index_ok;
} envelope_report_t;

class binner_scoreboard;
  logic [15:0]       bin_level [aeb_pkg::NUM_BINS];
  longint unsigned   accum;
  int unsigned       frames_in_bin;
  int unsigned       phase;
  int unsigned       filled;
  int unsigned       peak;
  bit                done;
  int unsigned       per_bin;
  int unsigned       chans;
  int unsigned       fmt;
  envelope_report_t  reports_due [$];
  int unsigned       mismatches;

  function new();
    clear_track();
    per_bin    = 1;
    chans      = 2;
    fmt        = 0;
    mismatches = 0;
  endfunction

  function void clear_track();
    accum         = 0;
    frames_in_bin = 0;
    phase         = 0;
    filled        = 0;
    peak          = 0;
    done          = 1'b0;
  endfunction

  function void write_reg(logic [1:0] index, logic [aeb_pkg::SPB_W-1:0] data);
    case (index)
      aeb_pkg::REG_SPB:     per_bin = data;
      aeb_pkg::REG_CHANNEL: chans = data[3:0];
      aeb_pkg::REG_FORMAT:  fmt = data[1:0];
      default: ;
    endcase
  endfunction

  // Q1.15 magnitude of one channel sample in the current format.
  function int unsigned magnitude_of(logic [31:0] v);
    int unsigned s;
    int unsigned m;
    case (fmt)
      aeb_pkg::FMT_S16: begin
        s = v[15:0];
        return v[15] ? (32'h10000 - s) : s;
      end
      aeb_pkg::FMT_S32: begin
        m = v[31] ? (32'd0 - v) : v;
        return m >> 16;
      end
      aeb_pkg::FMT_U8: begin
        s = v[7:0];
        return (s >= 128 ? s - 128 : 128 - s) * 256;
      end
      default: return 0;
    endcase
  endfunction

  function int unsigned scaled(int unsigned raw);
    longint unsigned r;
    if (!done || peak == 0) return raw;
    r = (longint'(raw) * 64'd32768) / peak;
    return (r > 32768) ? 32768 : int'(r);
  endfunction

  function void store_bin(int unsigned lvl);
    bin_level[filled] = lvl[15:0];
    filled++;
    if (lvl > peak) peak = lvl;
  endfunction

  function void owe(logic [1:0] kind, int unsigned index, int unsigned lvl, bit ok);
    envelope_report_t r;
    r.kind     = kind;
    r.index    = index[8:0];
    r.level    = lvl[15:0];
    r.peak     = peak[15:0];
    r.filled   = filled[9:0];
    r.fin      = done;
    r.index_ok = ok;
    reports_due.push_back(r);
  endfunction

  // Advance the envelope state by one accepted request.
  function void take_request(logic [1:0] req, frame_samples_t smp);
    int unsigned ch;
    int unsigned sum;
    int unsigned lvl;
    int unsigned index;
    int unsigned need;
    case (req)
      aeb_pkg::REQ_FRAME: begin
        if (done || filled >= aeb_pkg::NUM_BINS) return;
        if (phase != 0) begin
          phase = (phase + 1) % aeb_pkg::STRIDE;
          return;
        end
        phase = (phase + 1) % aeb_pkg::STRIDE;
        ch = chans;
        if (ch < 1) ch = 1;
        if (ch > aeb_pkg::MAX_CHANNELS) ch = aeb_pkg::MAX_CHANNELS;
        sum = 0;
        for (int c = 0; c < ch; c++) sum += magnitude_of(smp[c]);
        accum += sum / ch;
        frames_in_bin++;
        need = (per_bin != 0) ? per_bin : 1;
        if (frames_in_bin < need) return;
        lvl   = 32'(accum / frames_in_bin);
        index = filled;
        store_bin(lvl);
        accum         = 0;
        frames_in_bin = 0;
        if (filled >= aeb_pkg::NUM_BINS) done = 1'b1;
        owe(aeb_pkg::KIND_BIN, index, lvl, 1'b0);
      end
      aeb_pkg::REQ_FINISH: begin
        if (!done) begin
          if (frames_in_bin > 0 && filled < aeb_pkg::NUM_BINS)
            store_bin(32'(accum / frames_in_bin));
          accum         = 0;
          frames_in_bin = 0;
          done          = 1'b1;
        end
        owe(aeb_pkg::KIND_SUMMARY, 0, 0, 1'b0);
      end
      aeb_pkg::REQ_READ: begin
        index = smp[0];
        if (index < filled && index < aeb_pkg::NUM_BINS)
          owe(aeb_pkg::KIND_READ, index, scaled(bin_level[index]), 1'b1);
        else
          owe(aeb_pkg::KIND_READ, index, 0, 1'b0);
      end
      default: clear_track();
    endcase
  endfunction

  function void check_report(envelope_report_t got);
    envelope_report_t want;
    if (reports_due.size() == 0) begin
      if (mismatches < 10)
        $display("unexpected result: kind=%0d idx=%0d lvl=%0d peak=%0d filled=%0d fin=%0d iv=%0d",
                 got.kind, got.index, got.level, got.peak, got.filled, got.fin, got.index_ok);
      mismatches++;
      return;
    end
    want = reports_due.pop_front();
    if (got !== want) begin
      if (mismatches < 10) begin
        $display("result mismatch");
        $display("  expected kind=%0d idx=%0d lvl=%0d peak=%0d filled=%0d fin=%0d iv=%0d",
                 want.kind, want.index, want.level, want.peak, want.filled, want.fin,
                 want.index_ok);
        $display("  actual   kind=%0d idx=%0d lvl=%0d peak=%0d filled=%0d fin=%0d iv=%0d",
                 got.kind, got.index, got.level, got.peak, got.filled, got.fin, got.index_ok);
      end
      mismatches++;
    end
  endfunction
endclass

module audio_envelope_binner_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import aeb_pkg::*;

  // Hang guard, well above the slowest legal run (about 930 requests plus random
  // gaps and output stalls).
  localparam int CYCLE_LIMIT  = 1_000_000;
  // Margin for the longest internal work after the last transaction, a kept
  // frame closing a bin; round up generously.
  localparam int DRAIN_CYCLES = 120;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [1:0]           cfg_index = '0;
  logic [SPB_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           req_type = REQ_FRAME;
  logic signed [31:0]   sample_0 = '0;
  logic signed [31:0]   sample_1 = '0;
  logic signed [31:0]   sample_2 = '0;
  logic signed [31:0]   sample_3 = '0;
  logic signed [31:0]   sample_4 = '0;
  logic signed [31:0]   sample_5 = '0;
  logic signed [31:0]   sample_6 = '0;
  logic signed [31:0]   sample_7 = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           result_kind;
  logic [8:0]           bin_index;
  logic [15:0]          level;
  logic [15:0]          peak_level;
  logic [9:0]           bins_filled;
  logic                 finalized;
  logic                 index_valid;

  binner_scoreboard sb = new();

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int          cycles = 0;

  // Corner samples: every format's extremes and the offset-binary midpoint.
  logic [31:0] corner_samples [10] = '{
    32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_8000,
    32'h0000_7FFF, 32'h0000_0080, 32'h0000_007F, 32'h0000_00FF, 32'h0000_0001
  };

  audio_envelope_binner_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .sample_0    (sample_0),
    .sample_1    (sample_1),
    .sample_2    (sample_2),
    .sample_3    (sample_3),
    .sample_4    (sample_4),
    .sample_5    (sample_5),
    .sample_6    (sample_6),
    .sample_7    (sample_7),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_kind (result_kind),
    .bin_index   (bin_index),
    .level       (level),
    .peak_level  (peak_level),
    .bins_filled (bins_filled),
    .finalized   (finalized),
    .index_valid (index_valid)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Stall the result channel at random; a zero rate gives a clean stretch.
  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Sample every handshake with pre-edge values: register writes and accepted
  // requests feed the predictor, accepted results are checked in order.
  always @(posedge clk) begin
    frame_samples_t   smp;
    envelope_report_t got;
    if (!rst) begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) begin
        smp = '{sample_0, sample_1, sample_2, sample_3,
                sample_4, sample_5, sample_6, sample_7};
        sb.take_request(req_type, smp);
      end
      if (out_valid && !out_stall) begin
        got = {result_kind, bin_index, level, peak_level, bins_filled, finalized,
               index_valid};
        sb.check_report(got);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("audio_envelope_binner_core verification failed");
      $finish;
    end
  end

  // Present one transaction and hold it until accepted; optionally drop valid
  // for a random gap first. Leave valid high on return so back-to-back
  // requests stream without a bubble.
  task automatic send_item(input logic [1:0] req, input frame_samples_t smp);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    req_type <= req;
    sample_0 <= smp[0];
    sample_1 <= smp[1];
    sample_2 <= smp[2];
    sample_3 <= smp[3];
    sample_4 <= smp[4];
    sample_5 <= smp[5];
    sample_6 <= smp[6];
    sample_7 <= smp[7];
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid, wait for every owed result, then let in-flight work finish.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all three registers on consecutive edges; call only when idle.
  task automatic configure(input int unsigned per_bin, input int unsigned chans,
                           input int unsigned fmt);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SPB;
    cfg_data  <= per_bin[SPB_W-1:0];
    @(posedge clk);
    cfg_index <= REG_CHANNEL;
    cfg_data  <= SPB_W'(chans);
    @(posedge clk);
    cfg_index <= REG_FORMAT;
    cfg_data  <= SPB_W'(fmt);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [31:0] pick_sample();
    logic [31:0] v;
    if ($urandom_range(9) < 4) return $urandom;
    v = corner_samples[$urandom_range(9)];
    if ($urandom_range(1) == 1) v[31:16] = 16'($urandom);
    return v;
  endfunction

  function automatic frame_samples_t random_frame();
    frame_samples_t f;
    for (int i = 0; i < MAX_CHANNELS; i++) f[i] = pick_sample();
    return f;
  endfunction

  // Mostly indexes near the fill count, some far out of range.
  function automatic logic [31:0] read_index();
    case ($urandom_range(3))
      0, 1:    return $urandom_range(sb.filled + 1);
      2:       return $urandom_range(1023);
      default: return $urandom;
    endcase
  endfunction

  // Random request mix weighted toward frames so bins keep closing; clear a
  // finalized track soon so frames are not just ignored.
  task automatic random_traffic(input int count);
    int unsigned    r;
    frame_samples_t f;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      f = random_frame();
      if (sb.done && $urandom_range(3) == 0) begin
        send_item(REQ_CLEAR, f);
      end else if (r < 74) begin
        send_item(REQ_FRAME, f);
      end else if (r < 90) begin
        f[0] = read_index();
        send_item(REQ_READ, f);
      end else if (r < 95) begin
        send_item(REQ_FINISH, f);
      end else begin
        send_item(REQ_CLEAR, f);
      end
    end
  endtask

  task automatic random_phase(input int unsigned per_bin, input int unsigned chans,
                              input int unsigned fmt, input int unsigned idle,
                              input int unsigned stall, input int count);
    configure(per_bin, chans, fmt);
    send_idle_pct = idle;
    stall_pct     = stall;
    random_traffic(count);
    drain();
  endtask

  initial begin
    frame_samples_t f;
    frame_samples_t zeros;

    zeros = '{default: 32'h0};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: format extremes on all eight channels, stride drop, reads in
    // and out of range before and after finalization, repeated finish, frame
    // after finalization, clear, empty finish, and a zero-peak track.
    configure(1, 8, FMT_S16);
    f = '{32'hFFFF_8000, 32'h0000_7FFF, 32'h0, 32'hABCD_0001,
          32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_8000, 32'hFFFF_FFFF};
    send_item(REQ_FRAME, f);
    repeat (3) send_item(REQ_FRAME, random_frame());
    f = zeros;
    send_item(REQ_READ, f);
    f[0] = 32'hFFFF_FFFF;
    send_item(REQ_READ, f);
    f[0] = NUM_BINS;
    send_item(REQ_READ, f);
    send_item(REQ_FINISH, zeros);
    send_item(REQ_FINISH, zeros);
    send_item(REQ_READ, zeros);
    send_item(REQ_FRAME, random_frame());
    send_item(REQ_CLEAR, zeros);
    send_item(REQ_READ, zeros);
    send_item(REQ_FRAME, zeros);
    send_item(REQ_FINISH, zeros);
    send_item(REQ_READ, zeros);
    drain();

    // Directed: zero channel count falls back to one channel, signed 32-bit
    // extremes, and a finish that flushes a partial bin.
    configure(3, 0, FMT_S32);
    send_item(REQ_CLEAR, zeros);
    f = '{default: 32'h8000_0000};
    send_item(REQ_FRAME, f);
    repeat (3) send_item(REQ_FRAME, random_frame());
    f = '{default: 32'h7FFF_FFFF};
    send_item(REQ_FRAME, f);
    send_item(REQ_FINISH, zeros);
    send_item(REQ_READ, zeros);
    drain();

    // Random phases across register settings and handshake pressure.
    random_phase(1, 2, FMT_S16, 0, 0, 150);
    random_phase(2, 8, FMT_S32, 63, 0, 150);
    random_phase(5, 15, FMT_U8, 0, 63, 150);
    random_phase(0, 1, 3, 20, 20, 150);
    random_phase(24'hFF_FFFF, 0, FMT_S16, 20, 20, 150);
    random_phase(3, 4, FMT_U8, 0, 0, 150);

    if (sb.mismatches == 0 && sb.reports_due.size() == 0) begin
      $display("audio_envelope_binner_core verification clean");
    end else begin
      $display("audio_envelope_binner_core verification failed");
    end
    $finish;
  end

endmodule
